// ===== rtl/slrg_pkg.sv =====
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared constants and controller-to-datapath types for the subtractive
// lagged random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slrg_pkg;

    // Value width and modulus 2^31-1.
    localparam int unsigned VAL_W = 31;
    localparam logic [VAL_W-1:0] MOD_BIG = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SEED_BASE = 31'd161803398;

    // Table geometry: entries 1..55 are used, entry 0 is never touched.
    localparam int unsigned IDX_W = 6;
    localparam logic [IDX_W-1:0] TABLE_LAST = 6'd55;
    localparam logic [IDX_W-1:0] SCATTER_STEP = 6'd21;
    localparam logic [IDX_W-1:0] MIX_OFFSET = 6'd30;
    localparam logic [1:0] MIX_LAST_PASS = 2'd3;

    // Stream field widths.
    localparam int unsigned TDATA_W = 32;
    localparam int unsigned SEED_W = 32;

    // Request kinds carried in tuser.
    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;            // register the bound of an accepted request
        logic seed_start;         // derive the starting value from the seed
        logic scatter_top;        // write the starting value into entry 55
        logic scatter_step;       // write one scattered entry
        logic mix_rd;             // read the two operands of a mixing step
        logic mix_wr;             // write back a mixing difference
        logic idx_init;           // load the lead and trail pointers
        logic draw_rd;            // read the lead and trail entries
        logic draw_wr;            // write back the draw difference
        logic mul;                // scale the raw sample by the bound
        logic out_load;           // load the result register
        logic [IDX_W-1:0] idx;    // entry being mixed
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;           // result register can take a new value
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/subtractive_lagged_random_generator_unit.sv =====
// ----------------------------------------------------------------------------
// subtractive_lagged_random_generator_unit
// Subtractive lagged random generator with a 55-entry table modulo 2^31-1,
// reseed requests and optional exact scaling of each draw.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: func; tdata: max_value
//  m_axis    out        tdata: value
//  cfg       in         seed (signed, 32 bits)
//
//  A draw runs from acceptance to a valid result through one table read
//  of both entries, write-back of the difference, one multiply, and one
//  quotient and load step; the next item is accepted only after the load.
//  A reseed runs 1 setup step, 55 scatter writes and 4 x 55 mixing steps,
//  each a read and a write-back through the single table write port.
//  After reset the same seeding walk runs with seed 0 and s_axis is not
//  ready until it ends. A waiting result does not block acceptance of the
//  next item; the block stalls only when a new result must load.
// ----------------------------------------------------------------------------
`default_nettype none

module subtractive_lagged_random_generator_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [slrg_pkg::TDATA_W-1:0]       s_axis_tdata,  // [30:0] max_value
    input  wire logic                               s_axis_tuser,  // [0] func
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [slrg_pkg::TDATA_W-1:0]            m_axis_tdata,  // [30:0] value
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [slrg_pkg::SEED_W-1:0]        i_cfg_data
);

    slrg_pkg::t_dp_cmd cmd;
    slrg_pkg::t_dp_sts sts;
    logic [slrg_pkg::VAL_W-1:0] out_value;

    // Seed writes are always taken.
    assign o_cfg_ready = 1'b1;

    slrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    slrg_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_bound     (s_axis_tdata[slrg_pkg::VAL_W-1:0]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (out_value),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(slrg_pkg::TDATA_W-slrg_pkg::VAL_W){1'b0}}, out_value};

endmodule

`default_nettype wire

// ===== rtl/slrg_datapath.sv =====
// ----------------------------------------------------------------------------
// slrg_datapath
// Lag table memory, seed register, pointers, scaling multiplier, exact
// quotient by 2^31-1 and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire slrg_pkg::t_dp_cmd                  i_cmd,
    output slrg_pkg::t_dp_sts                       o_sts,
    input  wire logic [slrg_pkg::VAL_W-1:0]         i_bound,
    input  wire logic                               i_cfg_we,
    input  wire logic [slrg_pkg::SEED_W-1:0]        i_cfg_data,
    output logic                                    o_out_valid,
    output logic [slrg_pkg::VAL_W-1:0]              o_out_value,
    input  wire logic                               i_out_ready
);

    localparam int unsigned VW = slrg_pkg::VAL_W;
    localparam int unsigned IW = slrg_pkg::IDX_W;
    localparam int unsigned DEPTH = 56;

    // Subtraction modulo 2^31-1 of two in-range values.
    function automatic logic [VW-1:0] sub_mod(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b);
        logic [VW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d == {1'b0, slrg_pkg::MOD_BIG}) begin
            d = d - (VW+1)'(1);
        end else if (d[VW]) begin
            d = d + {1'b0, slrg_pkg::MOD_BIG};
        end
        return d[VW-1:0];
    endfunction

    // Pointer advance that wraps from 55 back to 1.
    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
        return (i >= slrg_pkg::TABLE_LAST) ? IW'(1) : i + IW'(1);
    endfunction

    logic [VW-1:0] r_mem [DEPTH];
    logic [VW-1:0] r_rd_a;
    logic [VW-1:0] r_rd_b;

    logic [slrg_pkg::SEED_W-1:0] r_seed;
    logic [VW-1:0] r_cur;
    logic [VW-1:0] r_nxt;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] r_lead;
    logic [IW-1:0] r_trail;
    logic [VW-1:0] r_bound;
    logic [VW-1:0] r_raw;
    logic [2*VW-1:0] r_prod;
    logic r_out_valid;
    logic [VW-1:0] r_out_value;

    logic [VW-1:0] seed_mag;
    logic [VW+1:0] seed_diff;
    logic [VW-1:0] seed_cur;
    logic [IW:0] pos_sum;
    logic [IW-1:0] pos_next;
    logic [IW:0] mix_sum;
    logic [IW-1:0] mix_partner;
    logic [IW-1:0] lead_next;
    logic [IW-1:0] trail_next;
    logic [IW-1:0] rd_addr_a;
    logic [IW-1:0] rd_addr_b;
    logic wr_en;
    logic [IW-1:0] wr_addr;
    logic [VW-1:0] wr_data;
    logic [VW-1:0] diff;
    logic [VW-1:0] quo_q0;
    logic [VW:0] quo_rem;
    logic [VW-1:0] quo;

    // Seed magnitude; the most negative seed maps to the modulus.
    always_comb begin
        if (r_seed == {1'b1, {(slrg_pkg::SEED_W-1){1'b0}}}) begin
            seed_mag = slrg_pkg::MOD_BIG;
        end else if (r_seed[slrg_pkg::SEED_W-1]) begin
            seed_mag = VW'(-r_seed);
        end else begin
            seed_mag = r_seed[VW-1:0];
        end
        seed_diff = {2'b00, slrg_pkg::SEED_BASE} - {2'b00, seed_mag};
        if (seed_diff[VW+1]) begin
            seed_diff = seed_diff + {2'b00, slrg_pkg::MOD_BIG};
        end
        seed_cur = seed_diff[VW-1:0];
    end

    // Scatter position steps by 21 modulo 55.
    assign pos_sum = {1'b0, r_pos} + {1'b0, slrg_pkg::SCATTER_STEP};
    assign pos_next = (pos_sum >= {1'b0, slrg_pkg::TABLE_LAST}) ?
                      IW'(pos_sum - {1'b0, slrg_pkg::TABLE_LAST}) : pos_sum[IW-1:0];

    // Mixing partner: 1 + (i + 30) mod 55.
    assign mix_sum = {1'b0, i_cmd.idx} + {1'b0, slrg_pkg::MIX_OFFSET};
    assign mix_partner = (mix_sum >= {1'b0, slrg_pkg::TABLE_LAST}) ?
                         IW'(mix_sum - {1'b0, slrg_pkg::TABLE_LAST} + (IW+1)'(1)) :
                         IW'(mix_sum + (IW+1)'(1));

    assign lead_next = next_idx(r_lead);
    assign trail_next = next_idx(r_trail);
    assign diff = sub_mod(r_rd_a, r_rd_b);

    // Read address selection.
    always_comb begin
        if (i_cmd.draw_rd) begin
            rd_addr_a = lead_next;
            rd_addr_b = trail_next;
        end else begin
            rd_addr_a = i_cmd.idx;
            rd_addr_b = mix_partner;
        end
    end

    // Write port selection.
    always_comb begin
        wr_en = 1'b0;
        wr_addr = i_cmd.idx;
        wr_data = diff;
        priority if (i_cmd.scatter_top) begin
            wr_en = 1'b1;
            wr_addr = slrg_pkg::TABLE_LAST;
            wr_data = r_cur;
        end else if (i_cmd.scatter_step) begin
            wr_en = 1'b1;
            wr_addr = r_pos;
            wr_data = r_nxt;
        end else if (i_cmd.mix_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.draw_wr) begin
            wr_en = 1'b1;
            wr_addr = lead_next;
        end
    end

    // Lag table memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.draw_rd || i_cmd.mix_rd) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    // Seed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_data;
        end
    end

    // Scatter state: the running pair of values and the position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_cur <= seed_cur;
            r_nxt <= VW'(1);
            r_pos <= slrg_pkg::SCATTER_STEP;
        end else if (i_cmd.scatter_step) begin
            r_nxt <= sub_mod(r_cur, r_nxt);
            r_cur <= r_nxt;
            r_pos <= pos_next;
        end
    end

    // Lead and trail pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_trail <= slrg_pkg::SCATTER_STEP;
        end else if (i_cmd.idx_init) begin
            r_lead <= '0;
            r_trail <= slrg_pkg::SCATTER_STEP;
        end else if (i_cmd.draw_wr) begin
            r_lead <= lead_next;
            r_trail <= trail_next;
        end
    end

    // Draw sample, bound and scaled product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bound <= i_bound;
        end
        if (i_cmd.draw_wr) begin
            r_raw <= diff;
        end
        if (i_cmd.mul) begin
            r_prod <= (2*VW)'(r_raw) * (2*VW)'(r_bound);
        end
    end

    // Exact quotient by 2^31-1: fold the high half, then correct up to twice.
    always_comb begin
        quo_q0 = r_prod[2*VW-1:VW];
        quo_rem = {1'b0, r_prod[VW-1:0]} + {1'b0, quo_q0};
        quo = quo_q0;
        if (quo_rem >= {1'b0, slrg_pkg::MOD_BIG}) begin
            quo = quo + VW'(1);
        end
        if (quo_rem >= {slrg_pkg::MOD_BIG, 1'b0}) begin
            quo = quo + VW'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= (r_bound == '0) ? r_raw : quo;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;

endmodule

`default_nettype wire

// ===== rtl/slrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// slrg_ctrl
// Sequencer for the generator: seeding walk (scatter and four mixing
// passes) and the draw steps.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_func,
    output logic                        o_in_ready,
    output slrg_pkg::t_dp_cmd           o_cmd,
    input  wire slrg_pkg::t_dp_sts      i_sts
);

    localparam int unsigned IW = slrg_pkg::IDX_W;

    typedef enum logic [3:0] {
        ST_SEED_START,
        ST_SCAT_TOP,
        ST_SCAT,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_MUL,
        ST_LOAD
    } t_state;

    t_state r_state;
    logic [IW-1:0] r_cnt;
    logic [1:0] r_pass;
    logic accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept = i_in_valid && o_in_ready;

    // State, step counter and pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SEED_START;
            r_cnt <= IW'(1);
            r_pass <= '0;
        end else begin
            unique case (r_state)
                ST_SEED_START: begin
                    r_state <= ST_SCAT_TOP;
                end
                ST_SCAT_TOP: begin
                    r_state <= ST_SCAT;
                    r_cnt <= IW'(1);
                end
                ST_SCAT: begin
                    if (r_cnt == slrg_pkg::TABLE_LAST - IW'(1)) begin
                        r_state <= ST_MIX_RD;
                        r_cnt <= IW'(1);
                        r_pass <= '0;
                    end else begin
                        r_cnt <= r_cnt + IW'(1);
                    end
                end
                ST_MIX_RD: begin
                    r_state <= ST_MIX_WR;
                end
                ST_MIX_WR: begin
                    if (r_cnt == slrg_pkg::TABLE_LAST) begin
                        r_cnt <= IW'(1);
                        r_pass <= r_pass + 2'd1;
                        r_state <= (r_pass == slrg_pkg::MIX_LAST_PASS) ? ST_IDLE : ST_MIX_RD;
                    end else begin
                        r_cnt <= r_cnt + IW'(1);
                        r_state <= ST_MIX_RD;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= (i_in_func == slrg_pkg::FUNC_DRAW) ?
                                   ST_DRAW_RD : ST_SEED_START;
                    end
                end
                ST_DRAW_RD: begin
                    r_state <= ST_DRAW_WR;
                end
                ST_DRAW_WR: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_SEED_START;
                end
            endcase
        end
    end

    // Command decode.
    always_comb begin
        o_cmd = '0;
        o_cmd.idx = r_cnt;
        o_cmd.capture = accept;
        o_cmd.seed_start = (r_state == ST_SEED_START);
        o_cmd.scatter_top = (r_state == ST_SCAT_TOP);
        o_cmd.scatter_step = (r_state == ST_SCAT);
        o_cmd.mix_rd = (r_state == ST_MIX_RD);
        o_cmd.mix_wr = (r_state == ST_MIX_WR);
        o_cmd.idx_init = (r_state == ST_MIX_WR) && (r_cnt == slrg_pkg::TABLE_LAST)
                         && (r_pass == slrg_pkg::MIX_LAST_PASS);
        o_cmd.draw_rd = (r_state == ST_DRAW_RD);
        o_cmd.draw_wr = (r_state == ST_DRAW_WR);
        o_cmd.mul = (r_state == ST_MUL);
        o_cmd.out_load = (r_state == ST_LOAD) && i_sts.out_free;
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives reseed and draw requests into the subtractive lagged random generator
// and compares every sample against a behavioral copy of the 55-entry table.
// ----------------------------------------------------------------------------

module testbench;

    // Table geometry and arithmetic constants, in integer form.
    localparam longint MODULUS = longint'(slrg_pkg::MOD_BIG);
    localparam longint SEED_START = longint'(slrg_pkg::SEED_BASE);
    localparam int LAST_ENTRY = int'(slrg_pkg::TABLE_LAST);
    localparam int SCATTER = int'(slrg_pkg::SCATTER_STEP);
    localparam int MIX_SHIFT = int'(slrg_pkg::MIX_OFFSET);
    localparam int MIX_ROUNDS = int'(slrg_pkg::MIX_LAST_PASS) + 1;

    // Wait length that covers a reseed walk, with some margin around it.
    localparam int SEED_WALK_CYCLES = 520;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 304;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_pattern;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [30:0] max_value
    logic        s_axis_tuser = 1'b0;  // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [30:0] value
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    // Behavioral copy of the generator state.
    logic [30:0] lag_entries [0:55];
    int          lead_pos;
    int          trail_pos;
    logic [31:0] seed_value;

    logic [30:0] expected_samples [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          sender_gap_max = 0;
    t_rx_pattern rx_pattern = RX_ALWAYS;
    int          rx_tick = 0;

    subtractive_lagged_random_generator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Rebuild the table from the current seed: scatter fill, then mixing.
    function automatic void reseed_table();
        longint signed_seed, magnitude, cur, nxt, diff;
        int pos;
        signed_seed = longint'($signed(seed_value));
        if (signed_seed == -64'sd2147483648) begin
            magnitude = MODULUS;
        end else begin
            magnitude = (signed_seed < 0) ? -signed_seed : signed_seed;
        end
        cur = SEED_START - magnitude;
        if (cur < 0) begin
            cur += MODULUS;
        end
        for (int i = 0; i <= LAST_ENTRY; i++) begin
            lag_entries[i] = '0;
        end
        lag_entries[LAST_ENTRY] = cur[30:0];
        nxt = 1;
        for (int i = 1; i < LAST_ENTRY; i++) begin
            pos = (SCATTER * i) % LAST_ENTRY;
            lag_entries[pos] = nxt[30:0];
            nxt = cur - nxt;
            if (nxt < 0) begin
                nxt += MODULUS;
            end
            cur = longint'(lag_entries[pos]);
        end
        for (int k = 0; k < MIX_ROUNDS; k++) begin
            for (int i = 1; i <= LAST_ENTRY; i++) begin
                diff = longint'(lag_entries[i])
                     - longint'(lag_entries[1 + (i + MIX_SHIFT) % LAST_ENTRY]);
                if (diff < 0) begin
                    diff += MODULUS;
                end
                lag_entries[i] = diff[30:0];
            end
        end
        lead_pos = 0;
        trail_pos = SCATTER;
    endfunction

    // Advance both lag pointers, store the difference and scale it if asked.
    function automatic logic [30:0] next_sample(input logic [30:0] bound);
        longint diff;
        longint unsigned scaled;
        lead_pos = (lead_pos + 1 > LAST_ENTRY) ? 1 : lead_pos + 1;
        trail_pos = (trail_pos + 1 > LAST_ENTRY) ? 1 : trail_pos + 1;
        diff = longint'(lag_entries[lead_pos]) - longint'(lag_entries[trail_pos]);
        if (diff == MODULUS) begin
            diff--;
        end
        if (diff < 0) begin
            diff += MODULUS;
        end
        lag_entries[lead_pos] = diff[30:0];
        scaled = longint'(diff);
        if (bound != '0) begin
            scaled = (scaled * longint'(bound)) / MODULUS;
        end
        return scaled[30:0];
    endfunction

    // Send one request, with burst gaps on the way; returns at acceptance.
    task automatic send_request(input logic func, input logic [30:0] bound);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gap_max != 0) begin
                gap = $urandom_range(0, sender_gap_max);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {1'b0, bound};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (func == slrg_pkg::FUNC_DRAW) begin
            expected_samples = {expected_samples, next_sample(bound)};
        end else begin
            reseed_table();
        end
    endtask

    // Hold the sender until every predicted sample has come out.
    task automatic drain_samples();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do begin
            @(posedge i_clk);
        end while (expected_samples.size() != 0);
    endtask

    // Drain, then let a reseed walk that may still be running finish.
    task automatic settle_idle();
        drain_samples();
        repeat (SEED_WALK_CYCLES) @(posedge i_clk);
    endtask

    // One configuration transaction; the block must be idle.
    task automatic write_seed(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        seed_value = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [30:0] pick_bound();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3:       return 31'($urandom_range(1, 16));
            4: begin
                case ($urandom_range(0, 3))
                    0:       return 31'h7FFF_FFFF;
                    1:       return 31'h7FFF_FFFE;
                    2:       return 31'd1;
                    default: return 31'h4000_0000;
                endcase
            end
            default: return 31'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 5))
            0:       return 32'($urandom_range(0, 1000));
            1:       return -32'($urandom_range(1, 1000));
            2:       return 32'(161803398 + $urandom_range(0, 4) - 2);
            3:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Draws from the power-up table, with the bound at its extremes.
    task automatic test_reset_seed_draws();
        send_request(slrg_pkg::FUNC_DRAW, 31'd0);
        send_request(slrg_pkg::FUNC_DRAW, 31'd0);
        send_request(slrg_pkg::FUNC_DRAW, 31'd1);
        send_request(slrg_pkg::FUNC_DRAW, 31'h7FFF_FFFF);
        send_request(slrg_pkg::FUNC_DRAW, 31'h7FFF_FFFE);
        send_request(slrg_pkg::FUNC_DRAW, 31'h4000_0000);
        send_request(slrg_pkg::FUNC_DRAW, 31'h2AAA_AAAA);
        send_request(slrg_pkg::FUNC_DRAW, 31'h5555_5555);
    endtask

    // A seed write alone must leave the running sequence untouched.
    task automatic test_seed_write_without_reseed();
        settle_idle();
        write_seed(32'd12345);
        send_request(slrg_pkg::FUNC_DRAW, 31'd0);
        send_request(slrg_pkg::FUNC_DRAW, 31'd0);
        send_request(slrg_pkg::FUNC_RESEED, 31'd0);
        send_request(slrg_pkg::FUNC_DRAW, 31'd0);
    endtask

    // Most negative seed, largest magnitudes and a start value that wraps.
    task automatic test_seed_extremes();
        logic [31:0] seeds [6];
        seeds = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'd161803399, 32'd161803398, 32'd0};
        foreach (seeds[n]) begin
            settle_idle();
            write_seed(seeds[n]);
            send_request(slrg_pkg::FUNC_RESEED, 31'h7FFF_FFFF);
            send_request(slrg_pkg::FUNC_DRAW, 31'd0);
        end
    endtask

    // Phases of random traffic, each under a fresh seed and a handshake pattern picked by phase number.
    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++) begin
            settle_idle();
            write_seed(pick_seed());
            sender_gap_max = (phase == 0) ? 0 : $urandom_range(1, 12);
            rx_pattern = t_rx_pattern'(phase % 4);
            send_request(slrg_pkg::FUNC_RESEED, pick_bound());
            for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) begin
                    drain_samples();
                end
                if ($urandom_range(0, 99) < 4) begin
                    send_request(slrg_pkg::FUNC_RESEED, pick_bound());
                end else begin
                    send_request(slrg_pkg::FUNC_DRAW, pick_bound());
                end
            end
        end
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        rx_tick++;
        case (rx_pattern)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_axis_tready <= ((rx_tick % 11) < 6);
            default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Compare each output transaction with the oldest predicted sample.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                $error("value: no sample expected, got %0d", m_axis_tdata[30:0]);
                error_count++;
            end else if (m_axis_tdata[30:0] !== expected_samples[0]) begin
                $error("value: expected %0d, got %0d",
                       expected_samples[0], m_axis_tdata[30:0]);
                error_count++;
                void'(expected_samples.pop_front());
            end else begin
                void'(expected_samples.pop_front());
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        seed_value = '0;
        reseed_table();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_seed_draws();
        test_seed_write_without_reseed();
        test_seed_extremes();
        test_random_traffic();

        settle_idle();
        if (expected_samples.size() != 0) begin
            $error("value: %0d expected samples never arrived", expected_samples.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== subtractive_lagged_random_generator_unit.f =====
rtl/slrg_pkg.sv
rtl/slrg_datapath.sv
rtl/slrg_ctrl.sv
rtl/subtractive_lagged_random_generator_unit.sv
tb/testbench.sv
